@@ design/ete_pkg.sv @@
package ete_pkg;

  localparam int MAX_EDGES    = 64;
  localparam int MAX_VERTICES = 256;
  localparam int IDX_W        = $clog2(MAX_EDGES);
  localparam int CNT_W        = $clog2(MAX_EDGES + 1);
  localparam int VTX_W        = 8;
  localparam int VCNT_W       = 9;
  localparam int WGT_W        = 16;
  localparam int CLR_W        = 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NOMATCH = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_RESOLVE
  } state_t;

  typedef struct packed {
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
    logic [WGT_W-1:0] weight;
    logic [CLR_W-1:0] color;
  } edge_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic shift;
  } cell_ctl_t;

endpackage

@@ design/edge_table_engine_top.sv @@
// accept in S_IDLE (capture), then S_RESOLVE registers the result
// no new item is accepted until the current one resolves; the match compare of
//   every cell is registered at accept and resolved with the shift or append
// a result waiting in the output register stalls only the resolve cycle
// reset: synchronous, active high; clears edge count, vertex count and handshakes
// table contents are not cleared; only entries below the edge count are read
module edge_table_engine_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ete_pkg::VCNT_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic [ete_pkg::VTX_W-1:0]    from_vertex,
  input  logic [ete_pkg::VTX_W-1:0]    to_vertex,
  input  logic signed [ete_pkg::WGT_W-1:0] edge_weight,
  input  logic [ete_pkg::CLR_W-1:0]    edge_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic                         found,
  output logic signed [ete_pkg::WGT_W-1:0] found_weight,
  output logic signed [ete_pkg::CLR_W:0]   found_color,
  output logic [ete_pkg::CNT_W-1:0]    entries_used
);
  import ete_pkg::*;

  state_t state, state_next;

  logic [VCNT_W-1:0] vertex_count;
  logic [VCNT_W-1:0] limit;
  logic [CNT_W-1:0]  total, total_next;

  op_t   op;
  logic  range_bad;
  edge_t item;

  logic accept, fire;
  logic do_append, do_remove;

  edge_t     entries [MAX_EDGES];
  logic [MAX_EDGES-1:0] hit_fwd, hit_rev, hits, below;
  cell_ctl_t ctl [MAX_EDGES];

  logic    any_hit;
  edge_t   sel;
  status_t stat_next;
  logic    found_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  assign limit = (vertex_count > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vertex_count;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    fire       = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (!out_valid || out_ready) begin
          fire       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= op_t'(opcode);
      range_bad   <= ({1'b0, from_vertex} >= limit) || ({1'b0, to_vertex} >= limit);
      item.src    <= from_vertex;
      item.dst    <= to_vertex;
      item.weight <= edge_weight;
      item.color  <= edge_color;
    end
  end

  // removal is directed, query matches either way
  assign hits = (op == OP_REMOVE) ? hit_fwd : (hit_fwd | hit_rev);

  ete_pick u_pick (
    .hits    (hits),
    .entries (entries),
    .any_hit (any_hit),
    .below   (below),
    .sel     (sel)
  );

  assign do_append = (op == OP_ADD) && !range_bad && (total != CNT_W'(MAX_EDGES));
  assign do_remove = (op == OP_REMOVE) && !range_bad && any_hit;

  for (genvar k = 0; k < MAX_EDGES; k++) begin : g_cell
    assign ctl[k].capture = accept;
    assign ctl[k].write   = fire && do_append && (total[IDX_W-1:0] == IDX_W'(k));
    assign ctl[k].shift   = fire && do_remove && !below[k];

    ete_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[k]),
      .live     (CNT_W'(k) < total),
      .key_src  (from_vertex),
      .key_dst  (to_vertex),
      .wr_entry (item),
      .nb_entry (entries[(k + 1 < MAX_EDGES) ? k + 1 : k]),
      .entry    (entries[k]),
      .hit_fwd  (hit_fwd[k]),
      .hit_rev  (hit_rev[k])
    );
  end

  always_comb begin
    total_next = total;
    if (do_append) begin
      total_next = total + CNT_W'(1);
    end else if (do_remove) begin
      total_next = total - CNT_W'(1);
    end
  end

  always_comb begin
    stat_next  = STAT_OK;
    found_next = 1'b0;
    if (op != OP_NOP) begin
      if (range_bad) begin
        stat_next = STAT_RANGE;
      end else begin
        case (op)
          OP_ADD: begin
            if (total == CNT_W'(MAX_EDGES)) begin
              stat_next = STAT_FULL;
            end
          end
          OP_REMOVE, OP_QUERY: begin
            found_next = any_hit;
            stat_next  = any_hit ? STAT_OK : STAT_NOMATCH;
          end
          default: stat_next = STAT_OK;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        total     <= total_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status       <= stat_next;
      found        <= found_next;
      entries_used <= total_next;
      if (found_next && (op == OP_QUERY)) begin
        found_weight <= sel.weight;
        found_color  <= {1'b0, sel.color};
      end else begin
        found_weight <= '1;
        found_color  <= '1;
      end
    end
  end

endmodule

@@ design/ete_cell.sv @@
module ete_cell (
  input  logic                    clk,
  input  ete_pkg::cell_ctl_t      ctl,
  input  logic                    live,
  input  logic [ete_pkg::VTX_W-1:0] key_src,
  input  logic [ete_pkg::VTX_W-1:0] key_dst,
  input  ete_pkg::edge_t          wr_entry,
  input  ete_pkg::edge_t          nb_entry,
  output ete_pkg::edge_t          entry,
  output logic                    hit_fwd,
  output logic                    hit_rev
);
  import ete_pkg::*;

  // write wins over shift; both never come together
  always_ff @(posedge clk) begin
    if (ctl.write) begin
      entry <= wr_entry;
    end else if (ctl.shift) begin
      entry <= nb_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hit_fwd <= live && (entry.src == key_src) && (entry.dst == key_dst);
      hit_rev <= live && (entry.src == key_dst) && (entry.dst == key_src);
    end
  end

endmodule

@@ design/ete_pick.sv @@
module ete_pick (
  input  logic [ete_pkg::MAX_EDGES-1:0] hits,
  input  ete_pkg::edge_t                entries [ete_pkg::MAX_EDGES],
  output logic                          any_hit,
  output logic [ete_pkg::MAX_EDGES-1:0] below,
  output ete_pkg::edge_t                sel
);
  import ete_pkg::*;

  logic [MAX_EDGES-1:0] first;

  // isolate lowest set bit, then mask of cells ahead of it
  assign first   = hits & (~hits + MAX_EDGES'(1));
  assign below   = first - MAX_EDGES'(1);
  assign any_hit = |hits;

  always_comb begin
    sel = '0;
    for (int k = 0; k < MAX_EDGES; k++) begin
      sel = sel | (first[k] ? entries[k] : edge_t'('0));
    end
  end

endmodule

@@ design/ete_checker.sv @@
module ete_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   status,
  input logic                         found,
  input logic signed [ete_pkg::WGT_W-1:0] found_weight,
  input logic signed [ete_pkg::CLR_W:0]   found_color,
  input logic [ete_pkg::CNT_W-1:0]    entries_used
);
  import ete_pkg::*;

  // count never passes capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entries_used <= CNT_W'(MAX_EDGES)))
    else $error("entries_used above capacity");

  // a hit always reports ok
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == STAT_OK))
    else $error("found with non-ok status");

  // rejected or missed items carry no weight or color
  a_miss_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (found_weight == '1 && found_color == '1))
    else $error("miss without all-ones fill");

  // one item in flight: no accept on the edge right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted item while one in flight");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind edge_table_engine_top ete_checker u_ete_checker (.*);
